FILE: rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants of the server configuration command parser.
// ----------------------------------------------------------------------------
package scc_pkg;

  // parser phases, one-hot
  typedef enum logic [12:0] {
    PH_START    = 13'b0_0000_0000_0001,
    PH_NOTCMD   = 13'b0_0000_0000_0010,
    PH_HASH     = 13'b0_0000_0000_0100,
    PH_KW_SRV   = 13'b0_0000_0000_1000,
    PH_KW_DBG   = 13'b0_0000_0001_0000,
    PH_KW_RST   = 13'b0_0000_0010_0000,
    PH_DBG_VAL  = 13'b0_0000_0100_0000,
    PH_DBG_ON   = 13'b0_0000_1000_0000,
    PH_DBG_OFF  = 13'b0_0001_0000_0000,
    PH_RST_DONE = 13'b0_0010_0000_0000,
    PH_HOST     = 13'b0_0100_0000_0000,
    PH_PORT     = 13'b0_1000_0000_0000,
    PH_BAD      = 13'b1_0000_0000_0000
  } phase_t;

  // flag bits
  localparam int unsigned FL_END     = 0;
  localparam int unsigned FL_NONIP   = 1;
  localparam int unsigned FL_IPBAD   = 2;
  localparam int unsigned FL_PORTBAD = 3;

  localparam logic [1:0] ST_NOTCMD  = 2'd0;
  localparam logic [1:0] ST_TOOLONG = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;
  localparam logic [1:0] ST_APPLIED = 2'd3;

  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_PROD   = 3'd1;
  localparam logic [2:0] ACT_TEST   = 3'd2;
  localparam logic [2:0] ACT_IPV4   = 3'd3;
  localparam logic [2:0] ACT_DOMAIN = 3'd4;
  localparam logic [2:0] ACT_DBG_ON = 3'd5;
  localparam logic [2:0] ACT_DBG_OFF = 3'd6;
  localparam logic [2:0] ACT_RESET  = 3'd7;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PROD_IPV4 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROD_PORT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_IPV4 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_PORT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DFLT_DBG  = 3'd4;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_R     = 8'h52;

  localparam logic [7:0] KW_SRV [5] = '{8'h23, 8'h53, 8'h52, 8'h56, 8'h3D};
  localparam logic [7:0] KW_DBG [5] = '{8'h23, 8'h44, 8'h42, 8'h47, 8'h3D};
  localparam logic [7:0] KW_RST [6] = '{8'h23, 8'h52, 8'h45, 8'h53, 8'h45, 8'h54};
  localparam logic [7:0] WD_PROD [4] = '{8'h50, 8'h52, 8'h4F, 8'h44};
  localparam logic [7:0] WD_TEST [4] = '{8'h54, 8'h45, 8'h53, 8'h54};

  localparam logic [15:0] PORT_RESET = 16'd80;
  localparam logic [31:0] IPV4_RESET = 32'd0;

  // line state after the current character
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  flags;
    logic [2:0]  dcount;
    logic        too_long;
    logic        host_ok;
    logic        host_empty;
    logic        host_len4;
    logic [31:0] ipv4;
    logic [15:0] port;
  } line_sum_t;

  // host store readback compare for the first four host bytes
  typedef struct packed {
    logic       vld;
    logic [1:0] idx;
  } cmp_t;

endpackage

FILE: rtl/scc_ram.sv
// ----------------------------------------------------------------------------
// scc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/scc_parser.sv
// ----------------------------------------------------------------------------
// scc_parser
// Per-character line parser: keyword match, dotted quad and port scan,
// host text write into the staging bank.
// ----------------------------------------------------------------------------
module scc_parser #(
  parameter int unsigned CMD_MAX  = 64,
  parameter int unsigned HOST_MAX = 64,
  localparam int unsigned SLW = $clog2(HOST_MAX + 1),
  localparam int unsigned AW  = $clog2(2 * HOST_MAX)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          character,
  input  logic                last,
  input  logic                active_bank,
  output scc_pkg::line_sum_t  sum,
  output logic [SLW-1:0]      slen,
  output scc_pkg::cmp_t       cmp,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data
);

  localparam int unsigned CCW = $clog2(CMD_MAX + 2);

  logic [CCW-1:0]        cc_r, cc_nxt;
  scc_pkg::phase_t       ph_r, ph_nxt;
  logic [7:0]            oct_r, oct_nxt;
  logic [2:0]            dc_r, dc_nxt;
  logic [1:0]            oi_r, oi_nxt;
  logic [31:0]           ip_r, ip_nxt;
  logic [15:0]           pt_r, pt_nxt;
  logic [3:0]            fl_r, fl_nxt;
  logic [SLW-1:0]        sl_r, sl_nxt;
  logic [11:0]           ov;
  logic [19:0]           pv;
  logic                  is_dig;

  assign is_dig = (character >= scc_pkg::CH_ZERO) && (character <= scc_pkg::CH_NINE);
  assign ov = 12'(oct_r) * 12'd10 + 12'(character[3:0]);
  assign pv = 20'(pt_r) * 20'd10 + 20'(character[3:0]);

  always_comb begin
    cc_nxt  = (cc_r <= CCW'(CMD_MAX)) ? cc_r + 1'b1 : cc_r;
    ph_nxt  = ph_r;
    oct_nxt = oct_r;
    dc_nxt  = dc_r;
    oi_nxt  = oi_r;
    ip_nxt  = ip_r;
    pt_nxt  = pt_r;
    fl_nxt  = fl_r;
    sl_nxt  = sl_r;
    wr_en   = 1'b0;
    cmp.vld = 1'b0;
    cmp.idx = sl_r[1:0];
    if (cc_r == '0) begin
      ph_nxt = (character == scc_pkg::CH_HASH) ? scc_pkg::PH_HASH : scc_pkg::PH_NOTCMD;
    end else if (!fl_r[scc_pkg::FL_END]) begin
      if (character == 8'd0) begin
        fl_nxt[scc_pkg::FL_END] = 1'b1;
      end else begin
        unique case (ph_r)
          scc_pkg::PH_HASH: begin
            priority if (character == scc_pkg::CH_S) ph_nxt = scc_pkg::PH_KW_SRV;
            else if (character == scc_pkg::CH_D) ph_nxt = scc_pkg::PH_KW_DBG;
            else if (character == scc_pkg::CH_R) ph_nxt = scc_pkg::PH_KW_RST;
            else ph_nxt = scc_pkg::PH_BAD;
          end
          scc_pkg::PH_KW_SRV: begin
            if (cc_r < CCW'(5) && scc_pkg::KW_SRV[cc_r[2:0]] == character) begin
              ph_nxt = (cc_r == CCW'(4)) ? scc_pkg::PH_HOST : scc_pkg::PH_KW_SRV;
            end else begin
              ph_nxt = scc_pkg::PH_BAD;
            end
          end
          scc_pkg::PH_KW_DBG: begin
            if (cc_r < CCW'(5) && scc_pkg::KW_DBG[cc_r[2:0]] == character) begin
              ph_nxt = (cc_r == CCW'(4)) ? scc_pkg::PH_DBG_VAL : scc_pkg::PH_KW_DBG;
            end else begin
              ph_nxt = scc_pkg::PH_BAD;
            end
          end
          scc_pkg::PH_KW_RST: begin
            if (cc_r < CCW'(6) && scc_pkg::KW_RST[cc_r[2:0]] == character) begin
              ph_nxt = (cc_r == CCW'(5)) ? scc_pkg::PH_RST_DONE : scc_pkg::PH_KW_RST;
            end else begin
              ph_nxt = scc_pkg::PH_BAD;
            end
          end
          scc_pkg::PH_DBG_VAL: begin
            priority if (character == scc_pkg::CH_ONE) ph_nxt = scc_pkg::PH_DBG_ON;
            else if (character == scc_pkg::CH_ZERO) ph_nxt = scc_pkg::PH_DBG_OFF;
            else ph_nxt = scc_pkg::PH_BAD;
          end
          scc_pkg::PH_HOST: begin
            if (character == scc_pkg::CH_COLON) begin
              // close the last octet
              if (dc_r == '0 || oi_r != 2'd3) fl_nxt[scc_pkg::FL_IPBAD] = 1'b1;
              else ip_nxt = {ip_r[23:0], oct_r};
              dc_nxt = '0;
              ph_nxt = scc_pkg::PH_PORT;
            end else begin
              if (sl_r < SLW'(HOST_MAX)) begin
                wr_en   = 1'b1;
                cmp.vld = (sl_r < SLW'(4));
                sl_nxt  = sl_r + 1'b1;
              end
              priority if (is_dig) begin
                if (ov > 12'd255 || dc_r >= 3'd3) fl_nxt[scc_pkg::FL_IPBAD] = 1'b1;
                else begin
                  oct_nxt = ov[7:0];
                  dc_nxt  = dc_r + 1'b1;
                end
              end else if (character == scc_pkg::CH_DOT) begin
                if (dc_r == '0 || oi_r == 2'd3) fl_nxt[scc_pkg::FL_IPBAD] = 1'b1;
                else begin
                  ip_nxt  = {ip_r[23:0], oct_r};
                  oi_nxt  = oi_r + 1'b1;
                  oct_nxt = '0;
                  dc_nxt  = '0;
                end
              end else begin
                fl_nxt[scc_pkg::FL_NONIP] = 1'b1;
              end
            end
          end
          scc_pkg::PH_PORT: begin
            if (is_dig && pv <= 20'd65535 && dc_r < 3'd5) begin
              pt_nxt = pv[15:0];
              dc_nxt = dc_r + 1'b1;
            end else begin
              fl_nxt[scc_pkg::FL_PORTBAD] = 1'b1;
            end
          end
          scc_pkg::PH_NOTCMD, scc_pkg::PH_BAD: ;
          default: ph_nxt = scc_pkg::PH_BAD;
        endcase
      end
    end
  end

  assign wr_addr = {~active_bank, sl_r[AW-2:0]};
  assign wr_data = character;

  assign sum.phase      = ph_nxt;
  assign sum.flags      = fl_nxt;
  assign sum.dcount     = dc_nxt;
  assign sum.too_long   = (cc_nxt > CCW'(CMD_MAX));
  assign sum.host_ok    = (sl_nxt < SLW'(HOST_MAX));
  assign sum.host_empty = (sl_nxt == '0);
  assign sum.host_len4  = (sl_nxt == SLW'(4));
  assign sum.ipv4       = ip_nxt;
  assign sum.port       = pt_nxt;
  assign slen           = sl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && last)) begin
      cc_r  <= '0;
      ph_r  <= scc_pkg::PH_START;
      oct_r <= '0;
      dc_r  <= '0;
      oi_r  <= '0;
      ip_r  <= '0;
      pt_r  <= '0;
      fl_r  <= '0;
      sl_r  <= '0;
    end else if (acc) begin
      cc_r  <= cc_nxt;
      ph_r  <= ph_nxt;
      oct_r <= oct_nxt;
      dc_r  <= dc_nxt;
      oi_r  <= oi_nxt;
      ip_r  <= ip_nxt;
      pt_r  <= pt_nxt;
      fl_r  <= fl_nxt;
      sl_r  <= sl_nxt;
    end
  end

endmodule

FILE: rtl/server_config_command_parser.sv
// ----------------------------------------------------------------------------
// server_config_command_parser
// Character-serial command line parser holding the active server settings.
// ----------------------------------------------------------------------------
// A result is registered in s1, then s2, then the output register before out_valid.
// Throughput: one character per cycle unless a held result waits on out_ready;
// the PROD/TEST host store readback, one RAM read behind the write, sets pipe depth.
// Reset (rst_n low, synchronous): line state cleared, active server = prod
// register reset values, debug off, configuration registers to reset values.
module server_config_command_parser #(
  parameter int unsigned CMD_MAX  = 64,
  parameter int unsigned HOST_MAX = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_character,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [2:0]                     out_action,
  output logic [15:0]                    out_server_port,
  output logic [31:0]                    out_server_ipv4,
  output logic                           out_host_is_domain,
  output logic [5:0]                     out_host_length,
  output logic                           out_debug_enabled,
  output logic                           out_resolution_cleared,
  input  logic                           cfg_we,
  input  logic [scc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_wdata
);

  localparam int unsigned SLW = $clog2(HOST_MAX + 1);
  localparam int unsigned AW  = $clog2(2 * HOST_MAX);
  localparam logic [31:0] IPV4_RESET_C = scc_pkg::IPV4_RESET;

  logic               adv, acc;
  scc_pkg::line_sum_t sum, s1_sum_r, s2_sum_r;
  logic [SLW-1:0]     slen, s1_sl_r, s2_sl_r;
  scc_pkg::cmp_t      cmp, s1_cmp_r, s2_cmp_r;
  logic               s1_vld_r, s2_vld_r, s1_last_r, s2_last_r;
  logic               wr_en;
  logic [AW-1:0]      wr_addr, s1_addr_r;
  logic [7:0]         wr_data, rd_q;

  logic [31:0] prod_ip_r, test_ip_r;
  logic [15:0] prod_pt_r, test_pt_r;
  logic        dflt_dbg_r;

  logic                bank_r, bank_nxt;
  logic [31:0]         aip_r, aip_nxt;
  logic [15:0]         apt_r, apt_nxt;
  logic                adom_r, adom_nxt;
  logic [SLW-1:0]      alen_r, alen_nxt;
  logic                dbg_r, dbg_nxt;
  logic [3:0]          pm_r, pm_nxt, tm_r, tm_nxt;
  logic [1:0]          st_nxt;
  logic [2:0]          act_nxt;
  logic                port_ok, is_ip;

  logic        ov_r;
  logic [1:0]  st_r;
  logic [2:0]  act_r;
  logic        clr_r;

  assign adv      = !ov_r || out_ready;
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_ip_r  <= IPV4_RESET_C;
      prod_pt_r  <= scc_pkg::PORT_RESET;
      test_ip_r  <= IPV4_RESET_C;
      test_pt_r  <= scc_pkg::PORT_RESET;
      dflt_dbg_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scc_pkg::REG_PROD_IPV4: prod_ip_r  <= cfg_wdata;
        scc_pkg::REG_PROD_PORT: prod_pt_r  <= cfg_wdata[15:0];
        scc_pkg::REG_TEST_IPV4: test_ip_r  <= cfg_wdata;
        scc_pkg::REG_TEST_PORT: test_pt_r  <= cfg_wdata[15:0];
        scc_pkg::REG_DFLT_DBG:  dflt_dbg_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  scc_parser #(.CMD_MAX(CMD_MAX), .HOST_MAX(HOST_MAX)) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .character   (in_character),
    .last        (in_last),
    .active_bank (bank_r),
    .sum         (sum),
    .slen        (slen),
    .cmp         (cmp),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  scc_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_host_store (
    .clk   (clk),
    .we    (acc && wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (adv),
    .raddr (s1_addr_r),
    .rdata (rd_q)
  );

  // stage 1: parser result; stage 2: host byte read back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= acc;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum_r  <= sum;
      s1_sl_r   <= slen;
      s1_cmp_r  <= cmp;
      s1_last_r <= in_last;
      s1_addr_r <= wr_addr;
      s2_sum_r  <= s1_sum_r;
      s2_sl_r   <= s1_sl_r;
      s2_cmp_r  <= s1_cmp_r;
      s2_last_r <= s1_last_r;
    end
  end

  assign port_ok = !s2_sum_r.flags[scc_pkg::FL_PORTBAD] && s2_sum_r.dcount != '0
                   && s2_sum_r.port != '0;
  assign is_ip   = !s2_sum_r.host_empty && !s2_sum_r.flags[scc_pkg::FL_NONIP];

  always_comb begin
    pm_nxt   = pm_r;
    tm_nxt   = tm_r;
    bank_nxt = bank_r;
    aip_nxt  = aip_r;
    apt_nxt  = apt_r;
    adom_nxt = adom_r;
    alen_nxt = alen_r;
    dbg_nxt  = dbg_r;
    st_nxt   = scc_pkg::ST_REJECT;
    act_nxt  = scc_pkg::ACT_NONE;
    if (s2_vld_r && s2_cmp_r.vld) begin
      pm_nxt[s2_cmp_r.idx] = (rd_q == scc_pkg::WD_PROD[s2_cmp_r.idx]);
      tm_nxt[s2_cmp_r.idx] = (rd_q == scc_pkg::WD_TEST[s2_cmp_r.idx]);
    end
    if (s2_sum_r.phase == scc_pkg::PH_NOTCMD) begin
      st_nxt = scc_pkg::ST_NOTCMD;
    end else if (s2_sum_r.too_long) begin
      st_nxt = scc_pkg::ST_TOOLONG;
    end else begin
      unique case (s2_sum_r.phase)
        scc_pkg::PH_DBG_ON: begin
          dbg_nxt = 1'b1;
          act_nxt = scc_pkg::ACT_DBG_ON;
        end
        scc_pkg::PH_DBG_OFF: begin
          dbg_nxt = 1'b0;
          act_nxt = scc_pkg::ACT_DBG_OFF;
        end
        scc_pkg::PH_RST_DONE: begin
          {aip_nxt, apt_nxt, adom_nxt, alen_nxt} = {prod_ip_r, prod_pt_r, 1'b0, SLW'(0)};
          dbg_nxt = dflt_dbg_r;
          act_nxt = scc_pkg::ACT_RESET;
        end
        scc_pkg::PH_HOST: begin
          if (s2_sum_r.host_len4 && pm_nxt == 4'hF) begin
            {aip_nxt, apt_nxt, adom_nxt, alen_nxt} = {prod_ip_r, prod_pt_r, 1'b0, SLW'(0)};
            act_nxt = scc_pkg::ACT_PROD;
          end else if (s2_sum_r.host_len4 && tm_nxt == 4'hF) begin
            {aip_nxt, apt_nxt, adom_nxt, alen_nxt} = {test_ip_r, test_pt_r, 1'b0, SLW'(0)};
            act_nxt = scc_pkg::ACT_TEST;
          end
        end
        scc_pkg::PH_PORT: begin
          if (port_ok && s2_sum_r.host_ok) begin
            if (is_ip) begin
              if (!s2_sum_r.flags[scc_pkg::FL_IPBAD]) begin
                {aip_nxt, apt_nxt, adom_nxt, alen_nxt} =
                  {s2_sum_r.ipv4, s2_sum_r.port, 1'b0, SLW'(0)};
                act_nxt = scc_pkg::ACT_IPV4;
              end
            end else begin
              // staged bank becomes active
              bank_nxt = ~bank_r;
              {aip_nxt, apt_nxt, adom_nxt, alen_nxt} =
                {32'd0, s2_sum_r.port, 1'b1, s2_sl_r};
              act_nxt = scc_pkg::ACT_DOMAIN;
            end
          end
        end
        default: ;
      endcase
      if (act_nxt != scc_pkg::ACT_NONE) st_nxt = scc_pkg::ST_APPLIED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r   <= '0;
      tm_r   <= '0;
      bank_r <= 1'b0;
      aip_r  <= IPV4_RESET_C;
      apt_r  <= scc_pkg::PORT_RESET;
      adom_r <= 1'b0;
      alen_r <= '0;
      dbg_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else if (adv) begin
      ov_r <= s2_vld_r && s2_last_r;
      if (s2_vld_r && s2_last_r) begin
        pm_r   <= '0;
        tm_r   <= '0;
        bank_r <= bank_nxt;
        aip_r  <= aip_nxt;
        apt_r  <= apt_nxt;
        adom_r <= adom_nxt;
        alen_r <= alen_nxt;
        dbg_r  <= dbg_nxt;
      end else if (s2_vld_r) begin
        pm_r <= pm_nxt;
        tm_r <= tm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_vld_r && s2_last_r) begin
      st_r  <= st_nxt;
      act_r <= act_nxt;
      clr_r <= (act_nxt != scc_pkg::ACT_NONE) && (act_nxt != scc_pkg::ACT_DBG_ON)
               && (act_nxt != scc_pkg::ACT_DBG_OFF);
    end
  end

  assign out_valid              = ov_r;
  assign out_status             = st_r;
  assign out_action             = act_r;
  assign out_server_port        = apt_r;
  assign out_server_ipv4        = aip_r;
  assign out_host_is_domain     = adom_r;
  assign out_host_length        = 6'(alen_r);
  assign out_debug_enabled      = dbg_r;
  assign out_resolution_cleared = clr_r;

endmodule

FILE: rtl/scc_checker.sv
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks of the command parser result channel.
// ----------------------------------------------------------------------------
module scc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [2:0]  out_action,
  input logic [31:0] out_server_ipv4,
  input logic        out_host_is_domain,
  input logic        out_resolution_cleared
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) && $stable(out_status))
    else $error("result dropped while stalled");

  a_applied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == scc_pkg::ST_APPLIED) == (out_action != scc_pkg::ACT_NONE)))
    else $error("status and action disagree");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_resolution_cleared |->
      out_status == scc_pkg::ST_APPLIED && out_action != scc_pkg::ACT_DBG_ON
      && out_action != scc_pkg::ACT_DBG_OFF)
    else $error("resolution cleared without server change");

  a_domain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_host_is_domain |-> out_server_ipv4 == 32'd0)
    else $error("domain host with nonzero ipv4");

endmodule

bind server_config_command_parser scc_checker u_scc_checker (.*);

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds command lines character by character into the server configuration
// command parser, predicts the settings each line leaves behind and compares
// every result field against that prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned LINE_MAX  = 64;
  localparam int unsigned HOSTS_MAX = 64;
  localparam int unsigned DOG_LIMIT = 20000;

  typedef enum int {
    P_START, P_NOTCMD, P_HASH, P_SRV, P_DBG, P_RST, P_DBGVAL, P_DBGON, P_DBGOFF,
    P_RSTDONE, P_HOST, P_PORT, P_BAD
  } pphase_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  action;
    logic [15:0] port;
    logic [31:0] ipv4;
    logic        is_domain;
    logic [5:0]  length;
    logic        debug;
    logic        cleared;
  } report_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_character;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [2:0]  out_action;
  logic [15:0] out_server_port;
  logic [31:0] out_server_ipv4;
  logic        out_host_is_domain;
  logic [5:0]  out_host_length;
  logic        out_debug_enabled;
  logic        out_resolution_cleared;
  logic        cfg_we;
  logic [scc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  server_config_command_parser dut (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // configuration copy
  logic [31:0] m_prod_ip, m_test_ip;
  logic [15:0] m_prod_port, m_test_port;
  logic        m_dflt_dbg;
  // line state
  int unsigned m_count, m_octet, m_dcount, m_oidx, m_port, m_slen;
  pphase_t     m_phase;
  logic [31:0] m_sip;
  logic        f_end, f_nonip, f_ipbad, f_portbad;
  logic [7:0]  m_store [2*HOSTS_MAX];
  // active settings
  logic        m_bank;
  logic [31:0] m_ip;
  logic [15:0] m_aport;
  logic        m_dom;
  logic [5:0]  m_len;
  logic        m_dbg;

  report_t expected_reports[$];
  int errors = 0;
  int dog = 0;
  int sent_lines = 0;
  // position of a zero byte in the line last built by rand_line, -1 for none
  int line_nul = -1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void clear_line_state();
    m_count = 0; m_phase = P_START; m_octet = 0; m_dcount = 0; m_oidx = 0;
    m_sip = '0; m_port = 0; m_slen = 0;
    f_end = 0; f_nonip = 0; f_ipbad = 0; f_portbad = 0;
  endfunction

  function automatic void load_server(input logic [31:0] ip, input logic [15:0] p);
    m_ip = ip; m_aport = p; m_dom = 0; m_len = 0;
  endfunction

  function automatic pphase_t match_word(input string kw, input int unsigned pos,
                                         input logic [7:0] c, input pphase_t here,
                                         input pphase_t nxt);
    if (pos >= kw.len() || kw[pos] != c) return P_BAD;
    return (pos + 1 == kw.len()) ? nxt : here;
  endfunction

  function automatic void host_byte(input logic [7:0] c);
    int unsigned v;
    if (m_slen < HOSTS_MAX) begin
      m_store[(m_bank ^ 1'b1) * HOSTS_MAX + m_slen] = c;
      m_slen++;
    end
    if (c >= "0" && c <= "9") begin
      v = m_octet * 10 + (c - "0");
      if (v > 255 || m_dcount >= 3) f_ipbad = 1;
      else begin m_octet = v; m_dcount++; end
    end else if (c == ".") begin
      if (m_dcount == 0 || m_oidx >= 3) f_ipbad = 1;
      else begin
        m_sip = (m_sip << 8) | m_octet;
        m_oidx++; m_octet = 0; m_dcount = 0;
      end
    end else begin
      f_nonip = 1;
    end
  endfunction

  function automatic void port_byte(input logic [7:0] c);
    int unsigned v;
    if (c >= "0" && c <= "9") begin
      v = m_port * 10 + (c - "0");
      if (v > 65535 || m_dcount >= 5) f_portbad = 1;
      else begin m_port = v; m_dcount++; end
    end else begin
      f_portbad = 1;
    end
  endfunction

  function automatic bit staged_word(input string w);
    int unsigned base;
    base = (m_bank ^ 1'b1) * HOSTS_MAX;
    if (m_slen != 4) return 0;
    for (int i = 0; i < 4; i++) if (m_store[base + i] != w[i]) return 0;
    return 1;
  endfunction

  // predicts the line parser; pushes a report on the last character
  function automatic void predict_char(input logic [7:0] c, input logic last);
    int unsigned pos;
    report_t r;
    bit port_ok, is_ip;
    pos = m_count;
    if (m_count <= LINE_MAX) m_count++;
    if (pos == 0) m_phase = (c == scc_pkg::CH_HASH) ? P_HASH : P_NOTCMD;
    else if (!f_end) begin
      if (c == 8'd0) f_end = 1;
      else begin
        case (m_phase)
          P_HASH: m_phase = (c == "S") ? P_SRV : (c == "D") ? P_DBG :
                            (c == "R") ? P_RST : P_BAD;
          P_SRV: m_phase = match_word("#SRV=", pos, c, P_SRV, P_HOST);
          P_DBG: m_phase = match_word("#DBG=", pos, c, P_DBG, P_DBGVAL);
          P_RST: m_phase = match_word("#RESET", pos, c, P_RST, P_RSTDONE);
          P_DBGVAL: m_phase = (c == "1") ? P_DBGON : (c == "0") ? P_DBGOFF : P_BAD;
          P_HOST: begin
            if (c == scc_pkg::CH_COLON) begin
              if (m_dcount == 0 || m_oidx != 3) f_ipbad = 1;
              else m_sip = (m_sip << 8) | m_octet;
              m_dcount = 0;
              m_phase = P_PORT;
            end else host_byte(c);
          end
          P_PORT: port_byte(c);
          P_NOTCMD, P_BAD: ;
          default: m_phase = P_BAD;
        endcase
      end
    end
    if (!last) return;
    r.status = scc_pkg::ST_REJECT;
    r.action = scc_pkg::ACT_NONE;
    if (m_phase == P_NOTCMD) r.status = scc_pkg::ST_NOTCMD;
    else if (m_count > LINE_MAX) r.status = scc_pkg::ST_TOOLONG;
    else if (m_phase == P_DBGON) begin m_dbg = 1; r.action = scc_pkg::ACT_DBG_ON; end
    else if (m_phase == P_DBGOFF) begin m_dbg = 0; r.action = scc_pkg::ACT_DBG_OFF; end
    else if (m_phase == P_RSTDONE) begin
      load_server(m_prod_ip, m_prod_port); m_dbg = m_dflt_dbg;
      r.action = scc_pkg::ACT_RESET;
    end else if (m_phase == P_HOST) begin
      if (staged_word("PROD")) begin
        load_server(m_prod_ip, m_prod_port); r.action = scc_pkg::ACT_PROD;
      end else if (staged_word("TEST")) begin
        load_server(m_test_ip, m_test_port); r.action = scc_pkg::ACT_TEST;
      end
    end else if (m_phase == P_PORT) begin
      port_ok = !f_portbad && m_dcount != 0 && m_port != 0;
      is_ip = m_slen != 0 && !f_nonip;
      if (port_ok && m_slen < HOSTS_MAX) begin
        if (is_ip) begin
          if (!f_ipbad) begin
            load_server(m_sip, m_port[15:0]); r.action = scc_pkg::ACT_IPV4;
          end
        end else begin
          m_bank ^= 1'b1;
          m_ip = '0; m_aport = m_port[15:0]; m_dom = 1; m_len = m_slen[5:0];
          r.action = scc_pkg::ACT_DOMAIN;
        end
      end
    end
    r.cleared = 0;
    if (r.action != scc_pkg::ACT_NONE) begin
      r.status = scc_pkg::ST_APPLIED;
      r.cleared = (r.action <= scc_pkg::ACT_DOMAIN || r.action == scc_pkg::ACT_RESET);
    end
    r.port = m_aport; r.ipv4 = m_ip; r.is_domain = m_dom; r.length = m_len;
    r.debug = m_dbg;
    expected_reports.push_back(r);
    clear_line_state();
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  bit sender_busy_gaps = 1;

  // valid drops only when a gap follows; wait_drained drops it at the end
  task automatic send_char(input logic [7:0] c, input logic last);
    int g;
    g = sender_busy_gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1; in_character <= c; in_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_char(c, last);
    @(negedge clk);
  endtask

  task automatic send_line(input string s, input int nul_at = -1);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = (i == nul_at) ? 8'd0 : 8'(s[i]);
      send_char(c, i == s.len() - 1);
    end
    sent_lines++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [scc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      scc_pkg::REG_PROD_IPV4: m_prod_ip = v;
      scc_pkg::REG_PROD_PORT: m_prod_port = v[15:0];
      scc_pkg::REG_TEST_IPV4: m_test_ip = v;
      scc_pkg::REG_TEST_PORT: m_test_port = v[15:0];
      scc_pkg::REG_DFLT_DBG:  m_dflt_dbg = v[0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] pip, input logic [15:0] pp,
                           input logic [31:0] tip, input logic [15:0] tp, input logic dd);
    wait_drained();
    write_reg(scc_pkg::REG_PROD_IPV4, pip);
    write_reg(scc_pkg::REG_PROD_PORT, {16'd0, pp});
    write_reg(scc_pkg::REG_TEST_IPV4, tip);
    write_reg(scc_pkg::REG_TEST_PORT, {16'd0, tp});
    write_reg(scc_pkg::REG_DFLT_DBG, {31'd0, dd});
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    report_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_status, out_action, out_server_port, out_server_ipv4,
              out_host_is_domain, out_host_length, out_debug_enabled,
              out_resolution_cleared};
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_status), 32'd0);
      end else begin
        want = expected_reports.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.action !== want.action)
          report_mismatch("action", 32'(got.action), 32'(want.action));
        if (got.port !== want.port)
          report_mismatch("port", 32'(got.port), 32'(want.port));
        if (got.ipv4 !== want.ipv4) report_mismatch("ipv4", got.ipv4, want.ipv4);
        if (got.is_domain !== want.is_domain)
          report_mismatch("is_domain", 32'(got.is_domain), 32'(want.is_domain));
        if (got.length !== want.length)
          report_mismatch("length", 32'(got.length), 32'(want.length));
        if (got.debug !== want.debug)
          report_mismatch("debug", 32'(got.debug), 32'(want.debug));
        if (got.cleared !== want.cleared)
          report_mismatch("cleared", 32'(got.cleared), 32'(want.cleared));
      end
    end
  end

  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = gap_len();
      out_ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) dog = 0;
    else dog++;
    if (dog >= DOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---- line generators ----
  function automatic string digits(input int unsigned v);
    return $sformatf("%0d", v);
  endfunction

  function automatic string rand_octet();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return digits($urandom_range(256, 999));
    if (k == 1) return "0001";
    if (k == 2) return "";
    return digits($urandom_range(0, 255));
  endfunction

  function automatic string rand_domain(input int unsigned n);
    string s;
    string abc;
    s = "";
    abc = "abcdefghijklmnopqrstuvwxyz0123456789.-ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    for (int i = 0; i < n; i++) s = {s, string'(abc[$urandom_range(0, abc.len() - 1)])};
    return s;
  endfunction

  function automatic string rand_port();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return "0";
    if (k == 1) return digits($urandom_range(65536, 99999));
    if (k == 2) return "000080";
    if (k == 3) return "";
    if (k == 4) return "8x0";
    return digits($urandom_range(1, 65535));
  endfunction

  // string bytes cannot hold zero; zero bytes go in through send_line
  function automatic string rand_noise(input int unsigned n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(1, 255)))};
    return s;
  endfunction

  function automatic string rand_line();
    int k;
    string h;
    line_nul = -1;
    k = $urandom_range(0, 99);
    if (k < 30) begin
      h = {rand_octet(), ".", rand_octet(), ".", rand_octet(), ".", rand_octet()};
      if ($urandom_range(0, 9) == 0) h = {h, ".", rand_octet()};
      return {"#SRV=", h, ":", rand_port()};
    end
    if (k < 50) return {"#SRV=", rand_domain($urandom_range(0, 12)), ":", rand_port()};
    if (k < 53) return {"#SRV=", rand_domain($urandom_range(50, 66)), ":80"};
    if (k < 60) return $urandom_range(0, 1) ? "#SRV=PROD" : "#SRV=TEST";
    if (k < 68) return $urandom_range(0, 1) ? "#DBG=1" : "#DBG=0";
    if (k < 72) return "#RESET";
    if (k < 76) begin
      line_nul = 14;
      return {"#SRV=1.2.3.4:5", "?", rand_noise($urandom_range(0, 5))};
    end
    if (k < 82) return {"#", rand_noise($urandom_range(0, 8))};
    if (k < 86) return rand_noise($urandom_range(1, 6));
    if (k < 89) return {"#SRV=", rand_domain($urandom_range(55, 70))};
    if (k < 93) return {"#DBG=", rand_noise($urandom_range(0, 2))};
    return {"#RES", rand_noise($urandom_range(0, 3))};
  endfunction

  // ---- tests ----
  task automatic test_directed();
    send_line("#SRV=PROD");
    send_line("#SRV=TEST");
    send_line("#SRV=192.168.1.10:8080");
    send_line("#SRV=255.255.255.255:65535");
    send_line("#SRV=0.0.0.0:1");
    send_line("#SRV=256.1.1.1:80");
    send_line("#SRV=1.2.3:80");
    send_line("#SRV=example.com:443");
    send_line("#SRV=:80");
    send_line("#SRV=host:0");
    send_line("#SRV=host:65536");
    send_line("#SRV=host:123456");
    send_line("#DBG=1");
    send_line("#DBG=0");
    send_line("#DBG=2");
    send_line("#RESET");
    send_line("#RESETX");
    send_line("hello");
    send_line("#SRV=PROD?junk", 9);
    send_line({"#SRV=", rand_domain(58), ":1"});
    send_line({"#SRV=", rand_domain(59), ":1"});
    send_line({"#", rand_domain(64)});
    send_line({string'(8'hFF), "x"});
    send_line({"#SRV=PRODX"});
  endtask

  task automatic test_config_extremes();
    write_all(32'hFFFF_FFFF, 16'd65535, 32'hFFFF_FFFF, 16'd65535, 1'b1);
    send_line("#RESET"); send_line("#SRV=PROD"); send_line("#SRV=TEST");
    write_all(32'h0, 16'd1, 32'h0, 16'd1, 1'b0);
    send_line("#RESET"); send_line("#SRV=TEST"); send_line("#SRV=PROD");
    write_all($urandom, 16'($urandom_range(1, 65535)), $urandom,
              16'($urandom_range(1, 65535)), 1'($urandom));
    send_line("#SRV=TEST"); send_line("#RESET");
  endtask

  task automatic test_random_lines(input int unsigned chars);
    int unsigned sent;
    string s;
    sent = 0;
    while (sent < chars) begin
      s = rand_line();
      send_line(s, line_nul);
      sent += s.len();
      if ($urandom_range(0, 60) == 0) wait_drained();
    end
  endtask

  task automatic test_back_to_back();
    string s;
    sender_busy_gaps = 0;
    for (int i = 0; i < 20; i++) begin
      s = rand_line();
      send_line(s, line_nul);
    end
    sender_busy_gaps = 1;
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_character = '0; in_last = 1'b0;
    out_ready = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    m_prod_ip = scc_pkg::IPV4_RESET; m_prod_port = scc_pkg::PORT_RESET;
    m_test_ip = scc_pkg::IPV4_RESET; m_test_port = scc_pkg::PORT_RESET;
    m_dflt_dbg = 1'b0;
    clear_line_state();
    foreach (m_store[i]) m_store[i] = 8'd0;
    m_bank = 0; m_dbg = 0;
    load_server(scc_pkg::IPV4_RESET, scc_pkg::PORT_RESET);
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_config_extremes();
    test_random_lines(700);
    write_all($urandom, 16'($urandom_range(1, 65535)), $urandom,
              16'($urandom_range(1, 65535)), 1'($urandom));
    test_back_to_back();
    test_random_lines(450);
    wait_drained();
    repeat (20) @(negedge clk);
    if (errors == 0 && expected_reports.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/scc_pkg.sv
rtl/scc_ram.sv
rtl/scc_parser.sv
rtl/server_config_command_parser.sv
rtl/scc_checker.sv
test/testbench.sv
